FILE: sv/lag_pkg.sv
// shared types, constants and field layout for the life automaton generation unit
// no dependencies

package lag_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;

    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int ACOL_W     = COL_W + 1;
    localparam int AROW_W     = ROW_W + 1;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int GRID_DEPTH = 1 << ADDR_W;

    localparam int ROW_FIELD_W = 7;
    localparam int COL_FIELD_W = 8;
    localparam int FUNC_W      = 2;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 8;

    localparam int GW_W       = 9;
    localparam int GH_W       = 8;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int GW_RESET   = 256;
    localparam int GH_RESET   = 128;

    localparam int SUM_W         = 4;
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_GEN   = 2'd2
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_WIDTH  = 1'b0,
        CFG_GRID_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic clr_en;
        logic accept;
        logic exec;
        logic scan_start;
        logic scan_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_gen;
        logic scan_last;
    } t_sts;

endpackage

FILE: sv/lag_datapath.sv
// grid memory, line buffers, 3x3 window, scan counters, config and result registers
// depends on lag_pkg

module lag_datapath import lag_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [IN_DATA_W-1:0]   i_s_tdata,
    input  logic [FUNC_W-1:0]      i_s_tuser,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic [OUT_DATA_W-1:0]  o_m_tdata
);

    logic [GW_W-1:0]        r_grid_width;
    logic [GH_W-1:0]        r_grid_height;
    logic [ACOL_W-1:0]      w_act_cols;
    logic [AROW_W-1:0]      w_act_rows;

    logic [FUNC_W-1:0]      r_func;
    logic [ROW_FIELD_W-1:0] r_row;
    logic [COL_FIELD_W-1:0] r_col;
    logic                   r_val;
    logic                   w_in_range;
    logic [ADDR_W-1:0]      w_item_addr;

    logic [ADDR_W-1:0]      r_clr_addr;

    logic [AROW_W-1:0]      r_si;
    logic [ACOL_W-1:0]      r_sj;
    logic                   w_si_in;
    logic                   w_sj_in;
    logic [ADDR_W-1:0]      w_scan_addr;

    logic                   r_p1_v;
    logic [AROW_W-1:0]      r_p1_i;
    logic [ACOL_W-1:0]      r_p1_j;
    logic                   r_p1_inx;
    logic                   r_p1_incol;

    logic                   r_grid_mem [GRID_DEPTH];
    logic                   r_grid_q;
    logic                   r_lb1 [MAX_COLS];
    logic                   r_lb2 [MAX_COLS];
    logic                   r_lb1_q;
    logic                   r_lb2_q;

    logic                   w_grid_re;
    logic [ADDR_W-1:0]      w_grid_raddr;
    logic                   w_grid_we;
    logic [ADDR_W-1:0]      w_grid_waddr;
    logic                   w_grid_wdata;
    logic                   w_lb_re;

    logic                   w_x;
    logic                   w_l1;
    logic                   w_l2;
    logic [2:0]             w_right;
    logic [2:0]             w_mid;
    logic [2:0]             w_left;
    logic [2:0]             r_wl;
    logic [2:0]             r_wc;
    logic [SUM_W-1:0]       w_sum;
    logic                   w_next;
    logic                   w_wb_en;
    logic [AROW_W-1:0]      w_wb_row;
    logic [ACOL_W-1:0]      w_wb_col;
    logic [ADDR_W-1:0]      w_wb_addr;

    logic                   r_out_rd;
    logic                   r_out_oor;
    logic                   w_is_access;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= GW_W'(GW_RESET);
            r_grid_height <= GH_W'(GH_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_GRID_WIDTH) begin
                r_grid_width <= i_cfg_data[GW_W-1:0];
            end
            if (i_cfg_idx == CFG_GRID_HEIGHT) begin
                r_grid_height <= i_cfg_data[GH_W-1:0];
            end
        end
    end

    assign w_act_cols = (32'(r_grid_width) >= 32'(MAX_COLS)) ? ACOL_W'(MAX_COLS)
                                                              : ACOL_W'(r_grid_width);
    assign w_act_rows = (32'(r_grid_height) >= 32'(MAX_ROWS)) ? AROW_W'(MAX_ROWS)
                                                               : AROW_W'(r_grid_height);

    // item latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_func <= i_s_tuser;
            r_row  <= i_s_tdata[ROW_FIELD_W-1:0];
            r_col  <= i_s_tdata[ROW_FIELD_W +: COL_FIELD_W];
            r_val  <= i_s_tdata[ROW_FIELD_W + COL_FIELD_W];
        end
    end

    assign w_in_range  = (32'(r_row) < 32'(w_act_rows)) && (32'(r_col) < 32'(w_act_cols));
    assign w_item_addr = {ROW_W'(r_row), COL_W'(r_col)};

    // clearing pass counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // raster scan over (rows + 1) x (cols + 1), the extra row and column read as dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_si <= '0;
            r_sj <= '0;
        end else if (i_cmd.scan_start) begin
            r_si <= '0;
            r_sj <= '0;
        end else if (i_cmd.scan_step) begin
            if (r_sj == w_act_cols) begin
                r_sj <= '0;
                r_si <= r_si + AROW_W'(1);
            end else begin
                r_sj <= r_sj + ACOL_W'(1);
            end
        end
    end

    assign w_si_in     = r_si < w_act_rows;
    assign w_sj_in     = r_sj < w_act_cols;
    assign w_scan_addr = {r_si[ROW_W-1:0], r_sj[COL_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v <= i_cmd.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step) begin
            r_p1_i     <= r_si;
            r_p1_j     <= r_sj;
            r_p1_inx   <= w_si_in && w_sj_in;
            r_p1_incol <= w_sj_in;
        end
    end

    // window column: bit 2 row i-2, bit 1 row i-1, bit 0 row i
    assign w_x     = r_p1_inx ? r_grid_q : 1'b0;
    assign w_l1    = (r_p1_incol && (r_p1_i >= AROW_W'(1))) ? r_lb1_q : 1'b0;
    assign w_l2    = (r_p1_incol && (r_p1_i >= AROW_W'(2))) ? r_lb2_q : 1'b0;
    assign w_right = {w_l2, w_l1, w_x};
    assign w_mid   = (r_p1_j == '0) ? 3'b000 : r_wc;
    assign w_left  = (r_p1_j == '0) ? 3'b000 : r_wl;

    assign w_sum = SUM_W'(w_left[0]) + SUM_W'(w_left[1]) + SUM_W'(w_left[2])
                 + SUM_W'(w_mid[0]) + SUM_W'(w_mid[2])
                 + SUM_W'(w_right[0]) + SUM_W'(w_right[1]) + SUM_W'(w_right[2]);

    assign w_next = (w_sum == SUM_W'(BIRTH_COUNT))
                 || ((w_sum == SUM_W'(SURVIVE_COUNT)) && w_mid[1]);

    always_ff @(posedge i_clk) begin
        if (r_p1_v) begin
            r_wl <= w_mid;
            r_wc <= w_right;
        end
    end

    assign w_wb_en   = r_p1_v && (r_p1_i != '0) && (r_p1_j != '0);
    assign w_wb_row  = r_p1_i - AROW_W'(1);
    assign w_wb_col  = r_p1_j - ACOL_W'(1);
    assign w_wb_addr = {w_wb_row[ROW_W-1:0], w_wb_col[COL_W-1:0]};

    // grid memory port selection
    always_comb begin
        w_grid_re    = 1'b0;
        w_grid_raddr = w_scan_addr;
        w_grid_we    = 1'b0;
        w_grid_waddr = w_wb_addr;
        w_grid_wdata = w_next;
        if (i_cmd.exec) begin
            w_grid_re    = 1'b1;
            w_grid_raddr = w_item_addr;
        end else if (i_cmd.scan_step && w_si_in && w_sj_in) begin
            w_grid_re = 1'b1;
        end
        if (i_cmd.clr_en) begin
            w_grid_we    = 1'b1;
            w_grid_waddr = r_clr_addr;
            w_grid_wdata = 1'b0;
        end else if (i_cmd.exec && (r_func == FUNC_WRITE) && w_in_range) begin
            w_grid_we    = 1'b1;
            w_grid_waddr = w_item_addr;
            w_grid_wdata = r_val;
        end else if (w_wb_en) begin
            w_grid_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_grid_we) begin
            r_grid_mem[w_grid_waddr] <= w_grid_wdata;
        end
        if (w_grid_re) begin
            r_grid_q <= r_grid_mem[w_grid_raddr];
        end
    end

    // line buffers holding the two previous rows
    assign w_lb_re = i_cmd.scan_step && w_sj_in;

    always_ff @(posedge i_clk) begin
        if (r_p1_v && r_p1_incol) begin
            r_lb1[r_p1_j[COL_W-1:0]] <= w_x;
            r_lb2[r_p1_j[COL_W-1:0]] <= r_lb1_q;
        end
        if (w_lb_re) begin
            r_lb1_q <= r_lb1[r_sj[COL_W-1:0]];
            r_lb2_q <= r_lb2[r_sj[COL_W-1:0]];
        end
    end

    // result word
    always_comb begin
        w_is_access = 1'b0;
        if (r_func inside {FUNC_WRITE, FUNC_READ}) begin
            w_is_access = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_rd  <= (r_func == FUNC_READ) && w_in_range && r_grid_q;
            r_out_oor <= w_is_access && !w_in_range;
        end
    end

    assign o_m_tdata = {(OUT_DATA_W-2)'(0), r_out_oor, r_out_rd};

    assign o_sts.clr_last  = r_clr_addr == ADDR_W'(GRID_DEPTH - 1);
    assign o_sts.is_gen    = r_func == FUNC_GEN;
    assign o_sts.scan_last = (r_si == w_act_rows) && (r_sj == w_act_cols);

endmodule

FILE: sv/lag_ctrl.sv
// sequencing state machine: clearing pass, cell access, generation scan, result handoff
// depends on lag_pkg

module lag_ctrl import lag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_GEN,
        S_DRAIN,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_m_valid;
    logic   n_m_valid;

    always_comb begin
        n_state   = r_state;
        n_m_valid = r_m_valid;
        o_cmd     = '0;
        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.is_gen) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_GEN;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_GEN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_m_valid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_m_valid      = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_tready = r_state == S_IDLE;
    assign o_m_tvalid = r_m_valid;

endmodule

FILE: sv/life_automaton_generation_unit.sv
// top level of the life automaton generation unit (B3/S23 on a bounded grid)
// depends on lag_pkg, lag_ctrl, lag_datapath
//
// Usage:
//   The slave stream carries one command word per item: tuser selects write cell,
//   read cell or advance one generation; tdata carries row, column and write value.
//   The master stream returns exactly one result word per item: read value and an
//   out-of-range flag for accesses outside the active width x height area.
//   Grid width and height are set through the write port; the user must set them
//   only while the unit is idle, which the block itself does not enforce.
// Timing:
//   A generation scans (height + 1) x (width + 1) cells, one per cycle through a
//   single-port read of the grid memory. One item is in progress at a time; the
//   next is taken once the current result sits in the output register.
// Reset:
//   After reset the unit runs a clearing pass over all 32768 grid cells, one cell
//   per cycle, with tready low; configuration writes are taken during it.
//   If the receiver stalls, the result holds in the output register; a following
//   item may be accepted and runs up to its own handoff, where it waits.

module life_automaton_generation_unit import lag_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // cell_row, cell_col, cell_value
    input  logic [FUNC_W-1:0]     i_s_tuser,   // func
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // read_value, out_of_range, zero pad
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    lag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lag_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

FILE: tb/life_automaton_generation_unit_tb.sv
// self-checking testbench for life_automaton_generation_unit: cell writes, reads and
// B3/S23 generations checked word by word against an in-bench grid predictor
// depends on lag_pkg and the life_automaton_generation_unit rtl
`timescale 1ns / 1ps

module life_automaton_generation_unit_tb;
    import lag_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
    localparam int RAND_ITEMS     = 1750;
    localparam int CALM_TAIL      = 200;
    localparam int GEN_COST_CAP   = 4000;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int STALL_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct packed {
        logic                  read_value;
        logic                  out_of_range;
    } cell_result_t;

    typedef struct packed {
        logic                  is_cfg;
        t_cfg_idx              reg_idx;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [FUNC_W-1:0]     op;
        logic [6:0]            row;
        logic [7:0]            col;
        logic                  val;
        logic                  typed;
        logic                  typed_rd;
        logic                  typed_oor;
    } stim_row_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;   // cell_row, cell_col, cell_value
    logic [FUNC_W-1:0]     i_s_tuser = '0;   // func
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;        // read_value, out_of_range, zero pad
    logic                  i_cfg_we = 1'b0;
    t_cfg_idx              i_cfg_idx = CFG_GRID_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic tag_typed = 1'b0;
    logic tag_rd = 1'b0;
    logic tag_oor = 1'b0;

    bit             life_cells  [MAX_ROWS][MAX_COLS];
    bit             prior_cells [MAX_ROWS][MAX_COLS];
    logic [GW_W-1:0] width_reg = GW_W'(GW_RESET);
    logic [GH_W-1:0] height_reg = GH_W'(GH_RESET);

    cell_result_t expected_words [$];
    int n_sent = 0;
    int n_results = 0;
    int n_errors = 0;
    int idle_cycles = 0;
    int hold_token = 0;
    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;

    stim_row_t directed_tab [29] = '{
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd127, 8'd255, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd127, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd127, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd0, 8'd0, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd0, 8'd1, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd0, 8'd2, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_NOP, 7'd127, 8'd255, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_GEN, 7'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd0, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd1, 8'd1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd127, 8'd255, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd0, 8'd6, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b1, CFG_GRID_WIDTH, 9'd5, FUNC_READ, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_GRID_HEIGHT, 9'h104, FUNC_READ, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd4, 8'd0, 1'b1, 1'b1, 1'b0, 1'b1},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd0, 8'd5, 1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd3, 8'd4, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd2, 8'd4, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_WRITE, 7'd3, 8'd3, 1'b1, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_GEN, 7'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd2, 8'd3, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd3, 8'd4, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_READ, 7'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b1},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_GEN, 7'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b1, CFG_GRID_WIDTH, 9'd511, FUNC_READ, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b1, CFG_GRID_HEIGHT, 9'd255, FUNC_READ, 7'd0, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, CFG_GRID_WIDTH, 9'd0, FUNC_GEN, 7'd0, 8'd0, 1'b0, 1'b1, 1'b0, 1'b0}
    };

    life_automaton_generation_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int used_cols();
        return (width_reg < MAX_COLS) ? int'(width_reg) : MAX_COLS;
    endfunction

    function automatic int used_rows();
        return (height_reg < MAX_ROWS) ? int'(height_reg) : MAX_ROWS;
    endfunction

    function automatic void advance_generation();
        int cols;
        int rows;
        int live;
        cols = used_cols();
        rows = used_rows();
        prior_cells = life_cells;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                live = 0;
                for (int dr = -1; dr <= 1; dr++)
                    for (int dc = -1; dc <= 1; dc++)
                        if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < rows
                            && c + dc >= 0 && c + dc < cols)
                            live += prior_cells[r + dr][c + dc];
                life_cells[r][c] = (live == BIRTH_COUNT) ||
                                   (live == SURVIVE_COUNT && prior_cells[r][c]);
            end
        end
    endfunction

    function automatic cell_result_t apply_cell_cmd(logic [FUNC_W-1:0] op, logic [6:0] row,
                                                    logic [7:0] col, logic val);
        cell_result_t res;
        res = '0;
        if (op == FUNC_WRITE || op == FUNC_READ) begin
            if (row < used_rows() && col < used_cols()) begin
                if (op == FUNC_WRITE)
                    life_cells[row][col] = val;
                else
                    res.read_value = life_cells[row][col];
            end else begin
                res.out_of_range = 1'b1;
            end
        end else if (op == FUNC_GEN) begin
            advance_generation();
        end
        return res;
    endfunction

    // result checking and prediction at each accepted word
    always @(posedge i_clk) begin
        cell_result_t want;
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            n_results++;
            if (expected_words.size() == 0) begin
                $error("result word %h with nothing expected", o_m_tdata);
                n_errors++;
            end else begin
                want = expected_words.pop_front();
                if (o_m_tdata[0] !== want.read_value) begin
                    $error("read_value: expected %0d, got %0b", want.read_value, o_m_tdata[0]);
                    n_errors++;
                end
                if (o_m_tdata[1] !== want.out_of_range) begin
                    $error("out_of_range: expected %0d, got %0b", want.out_of_range,
                           o_m_tdata[1]);
                    n_errors++;
                end
            end
        end
        if (i_rst_n && i_s_tvalid && o_s_tready === 1'b1) begin
            want = apply_cell_cmd(i_s_tuser, i_s_tdata[6:0], i_s_tdata[14:7], i_s_tdata[15]);
            if (tag_typed)
                want = '{read_value: tag_rd, out_of_range: tag_oor};
            expected_words.push_back(want);
        end
    end

    task automatic send_cmd(input logic [FUNC_W-1:0] op, input logic [6:0] row,
                            input logic [7:0] col, input logic val, input logic typed,
                            input logic rd, input logic oor);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {val, col, row};
        tag_typed  <= typed;
        tag_rd     <= rd;
        tag_oor    <= oor;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        n_sent++;
    endtask

    task automatic wait_all_results();
        i_s_tvalid <= 1'b0;
        wait (n_results == n_sent);
        @(posedge i_clk);
    endtask

    task automatic write_grid_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        if (idx == CFG_GRID_WIDTH)
            width_reg = value[GW_W-1:0];
        else
            height_reg = value[GH_W-1:0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver side: random back-pressure and one long hold-off on request
    initial begin
        int hold_seen;
        hold_seen = 0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_seen != hold_token) begin
                hold_seen = hold_token;
                i_m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge i_clk);
            end else if (rx_idle_en && $urandom_range(0, 2) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // sender side: reset, directed table, then random phases
    initial begin
        int n_rand;
        int phase;
        int phase_len;
        int w;
        int h;
        int pick;
        bit gen_ok;
        logic [FUNC_W-1:0] op;
        logic [6:0] row;
        logic [7:0] col;
        logic val;
        n_rand = 0;
        phase = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_tab[i]) begin
            if (directed_tab[i].is_cfg) begin
                wait_all_results();
                write_grid_reg(directed_tab[i].reg_idx, directed_tab[i].reg_data);
            end else begin
                send_cmd(directed_tab[i].op, directed_tab[i].row, directed_tab[i].col,
                         directed_tab[i].val, directed_tab[i].typed,
                         directed_tab[i].typed_rd, directed_tab[i].typed_oor);
            end
        end

        while (n_rand < RAND_ITEMS) begin
            wait_all_results();
            case ($urandom_range(0, 19))
                0, 1: begin
                    w = $urandom_range(1, 256);
                    h = $urandom_range(1, 4);
                end
                2, 3: begin
                    w = $urandom_range(1, 3);
                    h = $urandom_range(1, 128);
                end
                4: begin
                    w = $urandom_range(0, 1) ? 0 : $urandom_range(1, 20);
                    h = (w == 0) ? $urandom_range(0, 20) : 0;
                end
                5: begin
                    w = $urandom_range(257, 511);
                    h = $urandom_range(129, 255);
                end
                default: begin
                    w = $urandom_range(1, 24);
                    h = $urandom_range(1, 16);
                end
            endcase
            if (phase == 0) begin
                w = 1;
                h = 1;
            end
            write_grid_reg(CFG_GRID_WIDTH, w[CFG_DATA_W-1:0]);
            write_grid_reg(CFG_GRID_HEIGHT, {1'($urandom_range(0, 1)), h[GH_W-1:0]});
            gen_ok = (used_rows() + 1) * (used_cols() + 1) <= GEN_COST_CAP;
            tx_idle_en = (n_rand < RAND_ITEMS - CALM_TAIL) && $urandom_range(0, 3) != 0;
            rx_idle_en = (n_rand < RAND_ITEMS - CALM_TAIL) && $urandom_range(0, 3) != 0;
            if (phase == 2)
                hold_token++;
            phase_len = $urandom_range(30, 90);
            for (int k = 0; k < phase_len && n_rand < RAND_ITEMS; k++) begin
                if (phase == 3 && k == phase_len / 2)
                    wait_all_results();
                if (tx_idle_en && $urandom_range(0, 3) == 0) begin
                    i_s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 13)) @(posedge i_clk);
                end
                pick = $urandom_range(0, 99);
                row = 7'($urandom_range(0, 127));
                col = 8'($urandom_range(0, 255));
                val = 1'($urandom_range(0, 1));
                if (pick < 40)
                    op = FUNC_WRITE;
                else if (pick < 70)
                    op = FUNC_READ;
                else if (pick < 82)
                    op = gen_ok ? FUNC_GEN : FUNC_READ;
                else if (pick < 96)
                    op = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
                else
                    op = FUNC_NOP;
                if (pick < 82 && used_rows() > 0 && used_cols() > 0) begin
                    row = 7'($urandom_range(0, used_rows() - 1));
                    col = 8'($urandom_range(0, used_cols() - 1));
                end
                send_cmd(op, row, col, val, 1'b0, 1'b0, 1'b0);
                n_rand++;
                if (n_rand >= RAND_ITEMS - CALM_TAIL) begin
                    tx_idle_en = 1'b0;
                    rx_idle_en = 1'b0;
                end
            end
            phase++;
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_words.size() != 0) begin
            $error("%0d result words never arrived", expected_words.size());
            n_errors++;
        end
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/lag_pkg.sv
sv/lag_datapath.sv
sv/lag_ctrl.sv
sv/life_automaton_generation_unit.sv
tb/life_automaton_generation_unit_tb.sv
